/* hw/rtl/ktfl_pkg.sv */
// shared types, codes and constants of the keypad two-factor lock controller
package ktfl_pkg;

	localparam int DIGITS_DEF = 4;

	// controller states, one-hot
	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_ID       = 8'b0000_0010,
		S_IDWAIT   = 8'b0000_0100,
		S_CODE     = 8'b0000_1000,
		S_CODEWAIT = 8'b0001_0000,
		S_GRANT    = 8'b0010_0000,
		S_DENY     = 8'b0100_0000,
		S_ERR      = 8'b1000_0000
	} state_t;

	// lock_state codes seen on the result beat
	localparam logic [2:0] LS_IDLE     = 3'd0;
	localparam logic [2:0] LS_ID       = 3'd1;
	localparam logic [2:0] LS_IDWAIT   = 3'd2;
	localparam logic [2:0] LS_CODE     = 3'd3;
	localparam logic [2:0] LS_CODEWAIT = 3'd4;
	localparam logic [2:0] LS_GRANT    = 3'd5;
	localparam logic [2:0] LS_DENY     = 3'd6;
	localparam logic [2:0] LS_ERR      = 3'd7;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_BUTTON  = 2'd1,
		OP_KEY     = 2'd2,
		OP_VERDICT = 2'd3
	} op_t;

	localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
	localparam logic [3:0] KEY_CONFIRM    = 4'd12;
	localparam logic [3:0] KEY_CLEAR      = 4'd14;

	localparam logic [2:0] V_ID_OK        = 3'd0;
	localparam logic [2:0] V_ID_REFUSED   = 3'd1;
	localparam logic [2:0] V_CODE_OK      = 3'd2;
	localparam logic [2:0] V_CODE_REFUSED = 3'd3;

	localparam logic [2:0] LED_OFF   = 3'd0;
	localparam logic [2:0] LED_AMBER = 3'd1;
	localparam logic [2:0] LED_GREEN = 3'd2;
	localparam logic [2:0] LED_RED   = 3'd3;
	localparam logic [2:0] LED_BLUE  = 3'd4;

	localparam logic [6:0] ANGLE_OPEN = 7'd90;
	localparam logic [6:0] ANGLE_STEP = 7'd2;

	// register indexes
	localparam logic [2:0] REG_TIMEOUT   = 3'd0;
	localparam logic [2:0] REG_DISPLAY   = 3'd1;
	localparam logic [2:0] REG_DENY_BEEP = 3'd2;
	localparam logic [2:0] REG_STEP      = 3'd3;
	localparam logic [2:0] REG_BEEP      = 3'd4;

	localparam logic [23:0] TIMEOUT_RST   = 24'd50000;
	localparam logic [23:0] DISPLAY_RST   = 24'd8000;
	localparam logic [15:0] DENY_BEEP_RST = 16'd500;
	localparam logic [15:0] STEP_RST      = 16'd35;
	localparam logic [15:0] BEEP_RST      = 16'd5;

	// result beat field offsets in m_tdata
	localparam int TD_LOCK   = 0;
	localparam int TD_LED    = 3;
	localparam int TD_SID    = 6;
	localparam int TD_SCODE  = 7;
	localparam int TD_DIGITS = 8;
	localparam int TD_MAIL   = 24;
	localparam int TD_BUZ    = 25;
	localparam int TD_SERVO  = 26;
	localparam int TD_ANGLE  = 27;
	localparam int TD_CNT    = 34;
	localparam int TD_W      = 40;

	typedef struct packed {
		logic [23:0] timeout_ticks;
		logic [23:0] display_ticks;
		logic [15:0] deny_beep_ticks;
		logic [15:0] step_ticks;
		logic [15:0] beep_ticks;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  lock_state;
		logic [2:0]  led_color;
		logic        send_id;
		logic        send_code;
		logic [15:0] digits_out;
		logic        mail_valid;
		logic        mail_granted;
		logic        buzzer_on;
		logic        servo_enabled;
		logic [6:0]  servo_angle;
		logic [2:0]  entered_count;
	} result_t;

	function automatic logic [2:0] state_code(input state_t s);
		logic [2:0] c;
		case (s)
			S_IDLE:     c = LS_IDLE;
			S_ID:       c = LS_ID;
			S_IDWAIT:   c = LS_IDWAIT;
			S_CODE:     c = LS_CODE;
			S_CODEWAIT: c = LS_CODEWAIT;
			S_GRANT:    c = LS_GRANT;
			S_DENY:     c = LS_DENY;
			S_ERR:      c = LS_ERR;
			default:    c = LS_IDLE;
		endcase
		return c;
	endfunction

endpackage

/* hw/rtl/keypad_two_factor_lock_controller.sv */
// top level of the keypad two-factor lock controller: config registers and result register
//
//  channel  | dir | handshake               | contents
//  ---------+-----+-------------------------+-------------------------------------------
//  s_*      | in  | s_tvalid / s_tready     | one event beat (tick, button, key, verdict)
//  m_*      | out | m_tvalid / m_tready     | one result beat per event, state after it
//  apb      | in  | psel / penable, pready=1| five timing registers at 4*i
//
//  every event beat is handled at its accepting edge: the state machine in ktfl_core updates at that
//  edge and the result lands in the output register at the same edge
//  sustained rate is one beat per cycle; s_tready drops only while a result waits and the
//  sink is stalling, and comes back the cycle m_tready is seen
//  arst_n clears the state machine, the result valid flag and sets the registers to defaults
//  no clearing pass after reset: the first beat can be taken as soon as reset is released
module keypad_two_factor_lock_controller import ktfl_pkg::*; #(
	parameter int DIGITS = DIGITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// event stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // button_level[0], key_code[4:1], verdict[7:5]
	input  logic [1:0]  s_tuser,   // opcode[1:0]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // lock_state[2:0], led_color[5:3], send_id[6],
	                               // send_code[7], digits_out[23:8], mail_valid[24],
	                               // buzzer_on[25], servo_enabled[26],
	                               // servo_angle[33:27], entered_count[36:34], zeros
	output logic        m_tuser,   // mail_granted[0]
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t          cfg_q;
	result_t       res;
	logic          accept;
	logic          cfg_wr;
	logic [2:0]    reg_idx;
	logic          m_tvalid_q;
	logic [TD_W-1:0] m_tdata_q;
	logic          m_tuser_q;

	// output register frees as soon as the sink takes it, so no bubble between beats
	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	// register file, written only while idle by contract
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks   <= TIMEOUT_RST;
			cfg_q.display_ticks   <= DISPLAY_RST;
			cfg_q.deny_beep_ticks <= DENY_BEEP_RST;
			cfg_q.step_ticks      <= STEP_RST;
			cfg_q.beep_ticks      <= BEEP_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_TIMEOUT:   cfg_q.timeout_ticks   <= pwdata[23:0];
				REG_DISPLAY:   cfg_q.display_ticks   <= pwdata[23:0];
				REG_DENY_BEEP: cfg_q.deny_beep_ticks <= pwdata[15:0];
				REG_STEP:      cfg_q.step_ticks      <= pwdata[15:0];
				REG_BEEP:      cfg_q.beep_ticks      <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// read back, unused addresses read as zero
	always_comb begin
		case (reg_idx)
			REG_TIMEOUT:   prdata = {8'h00, cfg_q.timeout_ticks};
			REG_DISPLAY:   prdata = {8'h00, cfg_q.display_ticks};
			REG_DENY_BEEP: prdata = {16'h0000, cfg_q.deny_beep_ticks};
			REG_STEP:      prdata = {16'h0000, cfg_q.step_ticks};
			REG_BEEP:      prdata = {16'h0000, cfg_q.beep_ticks};
			default:       prdata = '0;
		endcase
	end

	// state machine and the whole per-event decision
	ktfl_core #(
		.DIGITS(DIGITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.opcode       (s_tuser),
		.button_level (s_tdata[0]),
		.key_code     (s_tdata[4:1]),
		.verdict      (s_tdata[7:5]),
		.cfg          (cfg_q),
		.res          (res)
	);

	// result beat valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// result payload, loaded on every accepted event beat
	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= {3'b000, res.entered_count, res.servo_angle, res.servo_enabled,
				res.buzzer_on, res.mail_valid, res.digits_out, res.send_code,
				res.send_id, res.led_color, res.lock_state};
			m_tuser_q <= res.mail_granted;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

/* hw/rtl/ktfl_core.sv */
// lock state machine: state registers and the per-event next-state logic
module ktfl_core import ktfl_pkg::*; #(
	parameter int DIGITS = DIGITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [1:0] opcode,
	input  logic       button_level,
	input  logic [3:0] key_code,
	input  logic [2:0] verdict,
	input  cfg_t       cfg,
	output result_t    res
);

	localparam int DW = 4 * DIGITS;
	localparam int CW = $clog2(DIGITS + 1);

	state_t        state_q, state_n;
	logic          phase_q, phase_n;
	logic [23:0]   elapsed_q, elapsed_n;
	logic [15:0]   sub_q, sub_n;
	logic [DW-1:0] id_q, id_n;
	logic [CW-1:0] id_cnt_q, id_cnt_n;
	logic [DW-1:0] code_q, code_n;
	logic [CW-1:0] code_cnt_q, code_cnt_n;
	logic          last_btn_q, last_btn_n;
	logic [2:0]    led_q, led_n;
	logic [6:0]    angle_q, angle_n;

	logic          go_en;
	state_t        go_st;
	logic          send_id, send_code, mail, mail_ok, buz;
	logic [DW-1:0] digits_p;
	logic [CW-1:0] cnt;
	logic [23:0]   e_inc;
	logic [15:0]   s_inc;
	logic [DW-1:0] ent_d;
	logic [CW-1:0] ent_c;
	op_t           op;

	logic [DW+15:0] digits_ext;
	logic [CW+2:0]  cnt_ext;

	assign op = op_t'(opcode);

	always_comb begin
		state_n    = state_q;
		phase_n    = phase_q;
		elapsed_n  = elapsed_q;
		sub_n      = sub_q;
		id_n       = id_q;
		id_cnt_n   = id_cnt_q;
		code_n     = code_q;
		code_cnt_n = code_cnt_q;
		last_btn_n = last_btn_q;
		led_n      = led_q;
		angle_n    = angle_q;
		go_en      = 1'b0;
		go_st      = state_q;
		send_id    = 1'b0;
		send_code  = 1'b0;
		mail       = 1'b0;
		mail_ok    = 1'b0;
		digits_p   = '0;
		buz        = 1'b0;
		cnt        = '0;
		e_inc      = elapsed_q + 24'd1;
		s_inc      = sub_q + 16'd1;
		ent_d      = (state_q == S_CODE) ? code_q : id_q;
		ent_c      = (state_q == S_CODE) ? code_cnt_q : id_cnt_q;

		case (op)
			OP_TICK: begin
				case (state_q)
					S_ID, S_IDWAIT, S_CODE, S_CODEWAIT: begin
						if (elapsed_q >= cfg.timeout_ticks) begin
							go_en = 1'b1;
							go_st = S_ERR;
						end else begin
							elapsed_n = e_inc;
						end
					end
					S_GRANT: begin
						if (!phase_q) begin
							// open hold at full angle
							if (e_inc >= cfg.display_ticks) begin
								phase_n   = 1'b1;
								sub_n     = '0;
								elapsed_n = '0;
							end else begin
								elapsed_n = e_inc;
							end
						end else if (s_inc >= cfg.step_ticks) begin
							if (angle_q < ANGLE_STEP) begin
								angle_n = '0;
								go_en   = 1'b1;
								go_st   = S_IDLE;
							end else begin
								angle_n = angle_q - ANGLE_STEP;
								sub_n   = '0;
							end
						end else begin
							sub_n = s_inc;
						end
					end
					S_DENY: begin
						if (!phase_q) begin
							if (e_inc >= {8'h00, cfg.deny_beep_ticks}) begin
								phase_n   = 1'b1;
								elapsed_n = '0;
							end else begin
								elapsed_n = e_inc;
							end
						end else if (e_inc >= cfg.display_ticks) begin
							go_en = 1'b1;
							go_st = S_IDLE;
						end else begin
							elapsed_n = e_inc;
						end
					end
					S_ERR: begin
						if (e_inc >= cfg.display_ticks) begin
							go_en = 1'b1;
							go_st = S_IDLE;
						end else begin
							elapsed_n = e_inc;
						end
					end
					default: begin
					end
				endcase
			end
			OP_BUTTON: begin
				if (state_q == S_IDLE) begin
					last_btn_n = button_level;
					if (button_level && !last_btn_q) begin
						go_en = 1'b1;
						go_st = S_ID;
					end
				end
			end
			OP_KEY: begin
				if (state_q == S_ID || state_q == S_CODE) begin
					if (key_code == KEY_CONFIRM) begin
						if (ent_c == CW'(DIGITS)) begin
							led_n    = LED_AMBER;
							digits_p = ent_d;
							go_en    = 1'b1;
							if (state_q == S_ID) begin
								send_id = 1'b1;
								go_st   = S_IDWAIT;
							end else begin
								send_code = 1'b1;
								go_st     = S_CODEWAIT;
							end
						end else begin
							ent_d = '0;
							ent_c = '0;
						end
					end else if (key_code == KEY_CLEAR) begin
						ent_d = '0;
						ent_c = '0;
					end else if (key_code <= KEY_LAST_DIGIT && ent_c < CW'(DIGITS)) begin
						ent_d = (ent_d << 4) | DW'(key_code);
						ent_c = ent_c + CW'(1);
					end
					if (state_q == S_ID) begin
						id_n     = ent_d;
						id_cnt_n = ent_c;
					end else begin
						code_n     = ent_d;
						code_cnt_n = ent_c;
					end
				end
			end
			OP_VERDICT: begin
				if (state_q == S_IDWAIT) begin
					go_en = 1'b1;
					if (verdict == V_ID_OK)           go_st = S_CODE;
					else if (verdict == V_ID_REFUSED) go_st = S_DENY;
					else                              go_st = S_ERR;
				end else if (state_q == S_CODEWAIT) begin
					go_en = 1'b1;
					if (verdict == V_CODE_OK)           go_st = S_GRANT;
					else if (verdict == V_CODE_REFUSED) go_st = S_DENY;
					else                                go_st = S_ERR;
				end
			end
			default: begin
			end
		endcase

		// state change side effects
		if (go_en) begin
			state_n   = go_st;
			elapsed_n = '0;
			phase_n   = 1'b0;
			sub_n     = '0;
			case (go_st)
				S_IDLE: begin
					led_n      = LED_OFF;
					code_n     = '0;
					code_cnt_n = '0;
				end
				S_ID: begin
					id_n     = '0;
					id_cnt_n = '0;
				end
				S_CODE: begin
					code_n     = '0;
					code_cnt_n = '0;
				end
				S_GRANT: begin
					led_n    = LED_GREEN;
					angle_n  = ANGLE_OPEN;
					mail     = 1'b1;
					mail_ok  = 1'b1;
					digits_p = id_n;
				end
				S_DENY: begin
					led_n    = LED_RED;
					mail     = 1'b1;
					digits_p = id_n;
				end
				S_ERR: begin
					led_n = LED_BLUE;
				end
				default: begin
				end
			endcase
		end

		if (state_n == S_GRANT)
			buz = phase_n && (sub_n < cfg.beep_ticks);
		else if (state_n == S_DENY)
			buz = !phase_n && (elapsed_n < {8'h00, cfg.deny_beep_ticks});
		if (state_n == S_ID)        cnt = id_cnt_n;
		else if (state_n == S_CODE) cnt = code_cnt_n;
	end

	assign digits_ext = {16'h0000, digits_p};
	assign cnt_ext    = {3'b000, cnt};

	always_comb begin
		res.lock_state    = state_code(state_n);
		res.led_color     = led_n;
		res.send_id       = send_id;
		res.send_code     = send_code;
		res.digits_out    = digits_ext[15:0];
		res.mail_valid    = mail;
		res.mail_granted  = mail_ok;
		res.buzzer_on     = buz;
		res.servo_enabled = (state_n == S_GRANT);
		res.servo_angle   = angle_n;
		res.entered_count = cnt_ext[2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			phase_q    <= 1'b0;
			elapsed_q  <= '0;
			sub_q      <= '0;
			id_q       <= '0;
			id_cnt_q   <= '0;
			code_q     <= '0;
			code_cnt_q <= '0;
			last_btn_q <= 1'b0;
			led_q      <= LED_OFF;
			angle_q    <= '0;
		end else if (accept) begin
			state_q    <= state_n;
			phase_q    <= phase_n;
			elapsed_q  <= elapsed_n;
			sub_q      <= sub_n;
			id_q       <= id_n;
			id_cnt_q   <= id_cnt_n;
			code_q     <= code_n;
			code_cnt_q <= code_cnt_n;
			last_btn_q <= last_btn_n;
			led_q      <= led_n;
			angle_q    <= angle_n;
		end
	end

endmodule

/* hw/rtl/ktfl_checker.sv */
// port-level checks of the lock controller, bound to the top level
module ktfl_checker import ktfl_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tuser
);

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// no pending result means the event side is open
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("event side blocked with empty result register");

	// at most one request pulse per beat
	a_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0({m_tdata[TD_SID], m_tdata[TD_SCODE], m_tdata[TD_MAIL]}))
		else $error("more than one request pulse in a beat");

	// digits only travel with a pulse, granted flag only with a mail
	a_digits: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[TD_SID] && !m_tdata[TD_SCODE] && !m_tdata[TD_MAIL]
		|-> m_tdata[TD_DIGITS+15:TD_DIGITS] == 16'h0000 && !m_tuser)
		else $error("digits or mail kind without a pulse");

	// servo driven exactly in the granted state
	a_servo: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[TD_SERVO] == (m_tdata[TD_LOCK+2:TD_LOCK] == LS_GRANT))
		else $error("servo enable disagrees with lock state");

endmodule

bind keypad_two_factor_lock_controller ktfl_checker u_ktfl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

/* test/keypad_two_factor_lock_controller_test.sv */
// self-checking testbench of the keypad two-factor lock controller
`timescale 1ns / 100ps

module keypad_two_factor_lock_controller_test;
	import ktfl_pkg::*;

	// cycles with no beat on any port before the run is declared hung
	localparam int QUIET_LIMIT = 2000;
	// a register index past the last one, writes to it must leave everything alone
	localparam logic [2:0] REG_UNUSED = 3'd5;
	// a key that is neither a digit, confirm nor clear
	localparam logic [3:0] KEY_F = 4'd15;
	// a verdict code outside the four known ones
	localparam logic [2:0] V_OTHER = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;    // button_level[0], key_code[4:1], verdict[7:5]
	logic [1:0]  s_tuser = '0;    // opcode[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;         // lock_state[2:0], led_color[5:3], send_id[6],
	                              // send_code[7], digits_out[23:8], mail_valid[24],
	                              // buzzer_on[25], servo_enabled[26],
	                              // servo_angle[33:27], entered_count[36:34], zeros
	logic        m_tuser;         // mail_granted[0]
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	keypad_two_factor_lock_controller dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------------------------
	// lock model: own copy of the timing registers and of the controller state
	// ---------------------------------------------------------------------------------
	cfg_t        lk_cfg = {TIMEOUT_RST, DISPLAY_RST, DENY_BEEP_RST, STEP_RST, BEEP_RST};
	logic [2:0]  lk_state = LS_IDLE;
	logic        lk_phase = 1'b0;
	logic [23:0] lk_elapsed = '0;
	logic [15:0] lk_sub = '0;
	logic [15:0] lk_id = '0;
	logic [2:0]  lk_id_cnt = '0;
	logic [15:0] lk_code = '0;
	logic [2:0]  lk_code_cnt = '0;
	logic        lk_last_btn = 1'b0;
	logic [2:0]  lk_led = LED_OFF;
	logic [6:0]  lk_angle = '0;

	// one-beat outputs of the event being modelled
	logic        pl_send_id, pl_send_code, pl_mail, pl_mail_ok;
	logic [15:0] pl_digits;

	// lock status expected on the result stream, oldest first
	result_t     expected_status[$];

	int          failures = 0;
	int          sent_events = 0;
	int          src_gap_pct = 0;
	int          sink_stall_pct = 0;
	int          calm_left = 0;
	int          quiet_cycles = 0;

	// every state change restarts the timers; some states also reset an entry or fire mail
	function automatic void enter_state(logic [2:0] s);
		lk_state = s;
		lk_elapsed = '0;
		lk_phase = 1'b0;
		lk_sub = '0;
		case (s)
			LS_IDLE: begin
				lk_led = LED_OFF;
				lk_code = '0;
				lk_code_cnt = '0;
			end
			LS_ID: begin
				lk_id = '0;
				lk_id_cnt = '0;
			end
			LS_CODE: begin
				lk_code = '0;
				lk_code_cnt = '0;
			end
			LS_GRANT: begin
				lk_led = LED_GREEN;
				lk_angle = ANGLE_OPEN;
				pl_mail = 1'b1;
				pl_mail_ok = 1'b1;
				pl_digits = lk_id;
			end
			LS_DENY: begin
				lk_led = LED_RED;
				pl_mail = 1'b1;
				pl_mail_ok = 1'b0;
				pl_digits = lk_id;
			end
			LS_ERR: lk_led = LED_BLUE;
			default: ;
		endcase
	endfunction

	// keypad handling shared by id entry and code entry
	function automatic void take_key(logic [3:0] key, bit is_id);
		logic [15:0] dig;
		logic [2:0]  cnt;
		dig = is_id ? lk_id : lk_code;
		cnt = is_id ? lk_id_cnt : lk_code_cnt;
		if (key == KEY_CONFIRM) begin
			if (cnt == 3'(DIGITS_DEF)) begin
				lk_led = LED_AMBER;
				pl_digits = dig;
				if (is_id) begin
					pl_send_id = 1'b1;
					enter_state(LS_IDWAIT);
				end else begin
					pl_send_code = 1'b1;
					enter_state(LS_CODEWAIT);
				end
			end else begin
				dig = '0;
				cnt = '0;
			end
		end else if (key == KEY_CLEAR) begin
			dig = '0;
			cnt = '0;
		end else if (key <= KEY_LAST_DIGIT && cnt < 3'(DIGITS_DEF)) begin
			dig = {dig[11:0], key};
			cnt = cnt + 3'd1;
		end
		if (is_id) begin
			lk_id = dig;
			lk_id_cnt = cnt;
		end else begin
			lk_code = dig;
			lk_code_cnt = cnt;
		end
	endfunction

	function automatic void advance_tick();
		case (lk_state)
			LS_ID, LS_IDWAIT, LS_CODE, LS_CODEWAIT: begin
				if (lk_elapsed >= lk_cfg.timeout_ticks)
					enter_state(LS_ERR);
				else
					lk_elapsed = lk_elapsed + 24'd1;
			end
			LS_GRANT: begin
				if (!lk_phase) begin
					// open hold
					lk_elapsed = lk_elapsed + 24'd1;
					if (lk_elapsed >= lk_cfg.display_ticks) begin
						lk_phase = 1'b1;
						lk_sub = '0;
						lk_elapsed = '0;
					end
				end else begin
					// closing, one step per step_ticks
					lk_sub = lk_sub + 16'd1;
					if (lk_sub >= lk_cfg.step_ticks) begin
						if (lk_angle < ANGLE_STEP) begin
							lk_angle = '0;
							enter_state(LS_IDLE);
						end else begin
							lk_angle = lk_angle - ANGLE_STEP;
							lk_sub = '0;
						end
					end
				end
			end
			LS_DENY: begin
				lk_elapsed = lk_elapsed + 24'd1;
				if (!lk_phase) begin
					if (lk_elapsed >= 24'(lk_cfg.deny_beep_ticks)) begin
						lk_phase = 1'b1;
						lk_elapsed = '0;
					end
				end else if (lk_elapsed >= lk_cfg.display_ticks) begin
					enter_state(LS_IDLE);
				end
			end
			LS_ERR: begin
				lk_elapsed = lk_elapsed + 24'd1;
				if (lk_elapsed >= lk_cfg.display_ticks)
					enter_state(LS_IDLE);
			end
			default: ;
		endcase
	endfunction

	// applies one event to the model and returns the status beat it should produce
	function automatic result_t lock_event(op_t op, logic btn, logic [3:0] key,
			logic [2:0] ver);
		result_t r;
		logic    rise;
		pl_send_id = 1'b0;
		pl_send_code = 1'b0;
		pl_mail = 1'b0;
		pl_mail_ok = 1'b0;
		pl_digits = '0;
		case (op)
			OP_TICK: advance_tick();
			OP_BUTTON: begin
				// the button is only watched while idle, level memory included
				if (lk_state == LS_IDLE) begin
					rise = btn && !lk_last_btn;
					lk_last_btn = btn;
					if (rise)
						enter_state(LS_ID);
				end
			end
			OP_KEY: begin
				if (lk_state == LS_ID)
					take_key(key, 1'b1);
				else if (lk_state == LS_CODE)
					take_key(key, 1'b0);
			end
			default: begin
				if (lk_state == LS_IDWAIT) begin
					if (ver == V_ID_OK)
						enter_state(LS_CODE);
					else if (ver == V_ID_REFUSED)
						enter_state(LS_DENY);
					else
						enter_state(LS_ERR);
				end else if (lk_state == LS_CODEWAIT) begin
					if (ver == V_CODE_OK)
						enter_state(LS_GRANT);
					else if (ver == V_CODE_REFUSED)
						enter_state(LS_DENY);
					else
						enter_state(LS_ERR);
				end
			end
		endcase

		r.lock_state = lk_state;
		r.led_color = lk_led;
		r.send_id = pl_send_id;
		r.send_code = pl_send_code;
		r.digits_out = pl_digits;
		r.mail_valid = pl_mail;
		r.mail_granted = pl_mail_ok;
		r.buzzer_on = 1'b0;
		if (lk_state == LS_GRANT)
			r.buzzer_on = lk_phase && (lk_sub < lk_cfg.beep_ticks);
		else if (lk_state == LS_DENY)
			r.buzzer_on = !lk_phase && (lk_elapsed < 24'(lk_cfg.deny_beep_ticks));
		r.servo_enabled = (lk_state == LS_GRANT);
		r.servo_angle = lk_angle;
		r.entered_count = '0;
		if (lk_state == LS_ID)
			r.entered_count = lk_id_cnt;
		else if (lk_state == LS_CODE)
			r.entered_count = lk_code_cnt;
		return r;
	endfunction

	// ---------------------------------------------------------------------------------
	// flow control: random stalls on both sides, broken by stretches of full rate
	// ---------------------------------------------------------------------------------
	always @(posedge clk) begin
		if (calm_left > 0)
			calm_left <= calm_left - 1;
		else if ($urandom_range(99) < 3)
			calm_left <= $urandom_range(10, 40);
	end

	always @(posedge clk)
		m_tready <= (calm_left > 0) || ($urandom_range(99) >= sink_stall_pct);

	// ---------------------------------------------------------------------------------
	// result checker: each status beat against the oldest expectation
	// ---------------------------------------------------------------------------------
	function automatic void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			failures++;
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_status.size() == 0) begin
				$error("status beat arrived with nothing expected");
				failures++;
			end else begin
				want = expected_status.pop_front();
				compare_field("lock_state", 32'(want.lock_state),
					32'(m_tdata[TD_LOCK +: 3]));
				compare_field("led_color", 32'(want.led_color),
					32'(m_tdata[TD_LED +: 3]));
				compare_field("send_id", 32'(want.send_id), 32'(m_tdata[TD_SID]));
				compare_field("send_code", 32'(want.send_code), 32'(m_tdata[TD_SCODE]));
				compare_field("digits_out", 32'(want.digits_out),
					32'(m_tdata[TD_DIGITS +: 16]));
				compare_field("mail_valid", 32'(want.mail_valid), 32'(m_tdata[TD_MAIL]));
				compare_field("mail_granted", 32'(want.mail_granted), 32'(m_tuser));
				compare_field("buzzer_on", 32'(want.buzzer_on), 32'(m_tdata[TD_BUZ]));
				compare_field("servo_enabled", 32'(want.servo_enabled),
					32'(m_tdata[TD_SERVO]));
				compare_field("servo_angle", 32'(want.servo_angle),
					32'(m_tdata[TD_ANGLE +: 7]));
				compare_field("entered_count", 32'(want.entered_count),
					32'(m_tdata[TD_CNT +: 3]));
			end
		end
	end

	// hang detection: any beat on either stream or an apb access counts as progress
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------------------------
	// drivers
	// ---------------------------------------------------------------------------------

	// one event beat; tvalid stays high after acceptance so back-to-back beats need
	// only one assignment per edge; a gap in the next call, or settle(), lowers it
	task automatic send_event(op_t op, logic btn, logic [3:0] key, logic [2:0] ver);
		while (calm_left == 0 && $urandom_range(99) < src_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {ver, key, btn};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_status.push_back(lock_event(op, btn, key, ver));
		sent_events++;
	endtask

	// fields that the event kind does not use still carry random bits
	task automatic send_tick();
		send_event(OP_TICK, 1'($urandom_range(1)), 4'($urandom_range(15)),
			3'($urandom_range(7)));
	endtask

	task automatic send_button(logic level);
		send_event(OP_BUTTON, level, 4'($urandom_range(15)), 3'($urandom_range(7)));
	endtask

	task automatic send_key(logic [3:0] key);
		send_event(OP_KEY, 1'($urandom_range(1)), key, 3'($urandom_range(7)));
	endtask

	task automatic send_verdict(logic [2:0] ver);
		send_event(OP_VERDICT, 1'($urandom_range(1)), 4'($urandom_range(15)), ver);
	endtask

	task automatic send_noise();
		send_event(op_t'($urandom_range(3)), 1'($urandom_range(1)),
			4'($urandom_range(15)), 3'($urandom_range(7)));
	endtask

	// stop the event stream and wait until every expected status beat is back
	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_status.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// apb write: setup, then access; the register takes the value at the access edge
	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_TIMEOUT:   lk_cfg.timeout_ticks = value[23:0];
			REG_DISPLAY:   lk_cfg.display_ticks = value[23:0];
			REG_DENY_BEEP: lk_cfg.deny_beep_ticks = value[15:0];
			REG_STEP:      lk_cfg.step_ticks = value[15:0];
			REG_BEEP:      lk_cfg.beep_ticks = value[15:0];
			default: ;
		endcase
		// idle gap so the next access starts on a fresh edge
		@(posedge clk);
	endtask

	// short timings so that every timed phase runs out many times
	task automatic program_short_timing();
		write_reg(REG_TIMEOUT, $urandom_range(1, 30));
		write_reg(REG_DISPLAY, $urandom_range(0, 6));
		write_reg(REG_DENY_BEEP, $urandom_range(0, 6));
		write_reg(REG_STEP, $urandom_range(1, 3));
		write_reg(REG_BEEP, $urandom_range(0, 4));
	endtask

	// ---------------------------------------------------------------------------------
	// sequences
	// ---------------------------------------------------------------------------------

	// ticks until the lock is idle again, with the odd stray event thrown in
	task automatic return_to_idle();
		int guard;
		guard = 0;
		while (lk_state != LS_IDLE && guard < 4000) begin
			if ($urandom_range(99) < 8)
				send_noise();
			else
				send_tick();
			guard++;
		end
	endtask

	// one id or code entry, mostly well formed, with ticks, dead keys and clears mixed in
	task automatic key_in_entry();
		int         held;
		int         roll;
		logic [3:0] dead_key;
		held = 0;
		while (held < DIGITS_DEF) begin
			roll = $urandom_range(99);
			if (roll < 15) begin
				send_tick();
			end else if (roll < 22) begin
				dead_key = KEY_CONFIRM;
				while (dead_key == KEY_CONFIRM || dead_key == KEY_CLEAR)
					dead_key = 4'($urandom_range(10, 15));
				send_key(dead_key);
			end else if (roll < 25) begin
				send_key(KEY_CLEAR);
				held = 0;
			end else begin
				send_key(4'($urandom_range(9)));
				held++;
			end
		end
		roll = $urandom_range(99);
		// a digit past the end is dropped; now and then the entry is left to time out
		if (roll < 6)
			send_key(4'($urandom_range(9)));
		if (roll < 92)
			send_key(KEY_CONFIRM);
	endtask

	// button press, id, verdict, code, verdict; optionally run out the grant or denial
	task automatic run_session(bit run_out);
		int roll;
		return_to_idle();
		send_button(1'b0);
		send_button(1'b1);
		key_in_entry();
		repeat ($urandom_range(2)) send_tick();
		roll = $urandom_range(99);
		if (roll < 75)
			send_verdict(V_ID_OK);
		else if (roll < 87)
			send_verdict(V_ID_REFUSED);
		else
			send_verdict(3'($urandom_range(7)));
		key_in_entry();
		repeat ($urandom_range(2)) send_tick();
		roll = $urandom_range(99);
		if (roll < 75)
			send_verdict(V_CODE_OK);
		else if (roll < 87)
			send_verdict(V_CODE_REFUSED);
		else
			send_verdict(3'($urandom_range(7)));
		if (run_out)
			return_to_idle();
	endtask

	// ---------------------------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------------------------

	// hand-picked events: ignored inputs, entry editing, wrong verdict, timeout
	task automatic test_directed();
		write_reg(REG_TIMEOUT, 32'd3);
		write_reg(REG_DISPLAY, 32'd2);
		write_reg(REG_DENY_BEEP, 32'd1);
		write_reg(REG_STEP, 32'd1);
		write_reg(REG_BEEP, 32'd1);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		send_tick();                        // tick while idle does nothing
		send_key(4'd5);                     // key while idle ignored
		send_verdict(V_ID_OK);              // verdict while idle ignored
		send_button(1'b1);                  // rising edge starts id entry
		send_key(KEY_F);                    // non-digit key ignored
		send_key(KEY_LAST_DIGIT);
		send_key(KEY_CLEAR);                // clear empties the entry
		send_key(4'd7);
		send_key(KEY_CONFIRM);              // confirm on a partial entry clears it
		send_key(4'd0);
		send_key(KEY_LAST_DIGIT);
		send_key(4'd0);
		send_key(KEY_LAST_DIGIT);
		send_key(4'd3);                     // entry full, digit dropped
		send_button(1'b0);                  // button outside idle ignored
		send_key(KEY_CONFIRM);              // id goes out
		send_verdict(V_OTHER);              // unknown verdict is an error
		send_tick();
		send_tick();                        // error display over, back to idle
		send_button(1'b1);                  // level memory still high, no edge
		send_button(1'b0);
		send_button(1'b1);
		repeat (4) send_tick();             // last tick trips the timeout
		settle();
	endtask

	task automatic test_random_traffic(int src_gap, int sink_stall, int events);
		int first;
		src_gap_pct = src_gap;
		sink_stall_pct = sink_stall;
		program_short_timing();
		first = sent_events;
		while (sent_events - first < events) begin
			if ($urandom_range(99) < 12)
				repeat ($urandom_range(1, 6)) send_noise();
			else
				run_session(1'b1);
		end
		settle();
	endtask

	// largest timings (upper bits of the write dropped), then the smallest ones
	task automatic test_config_extremes();
		src_gap_pct = 10;
		sink_stall_pct = 10;
		write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
		write_reg(REG_DISPLAY, 32'h00FF_FFFF);
		write_reg(REG_DENY_BEEP, 32'h0000_FFFF);
		write_reg(REG_STEP, 32'h0000_FFFF);
		write_reg(REG_BEEP, 32'hFFFF_FFFF);
		run_session(1'b0);
		repeat (40) send_tick();
		settle();
		write_reg(REG_TIMEOUT, 32'd1);
		write_reg(REG_DISPLAY, 32'd0);
		write_reg(REG_DENY_BEEP, 32'd0);
		write_reg(REG_STEP, 32'd1);
		write_reg(REG_BEEP, 32'd0);
		repeat (6) run_session(1'b1);
		settle();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_traffic(25, 51, 380);
		test_random_traffic(51, 25, 380);
		test_random_traffic(0, 0, 380);
		test_config_extremes();
		settle();
		if (failures == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
